// ===== src/bma_pkg.sv =====
// ----------------------------------------------------------------------------
// bma_pkg
// Shared constants and types for the boxcar moving-average filter.
// ----------------------------------------------------------------------------
`default_nettype none

package bma_pkg;

    // Window depth and sample width
    localparam int WINDOW_MAX  = 1024;
    localparam int SAMPLE_BITS = 24;

    // Derived widths
    localparam int ADDR_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int EFF_W   = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W   = SAMPLE_BITS + EFF_W;

    // Register field widths and fixed point format
    localparam int WL_W      = 11;
    localparam int RECIP_W   = 25;
    localparam int FRAC_BITS = 24;
    localparam int HI_W      = SUM_W - FRAC_BITS;

    // Configuration port
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_LENGTH_RECIP  = CFG_INDEX_W'(1);

    // Reset values
    localparam logic [WL_W-1:0]    WL_RESET    = WL_W'(1);
    localparam logic [RECIP_W-1:0] RECIP_RESET = RECIP_W'(1 << FRAC_BITS);

    // Per-request info handed from window control to the datapath
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] x;        // new sample
        logic signed [SAMPLE_BITS-1:0] alt_old;  // value used when entry is unwritten
        logic                          from_mem; // evicted value comes from RAM
        logic                          prime;    // first request after clear
        logic signed [SUM_W-1:0]       prime_sum;// x * window length
    } bma_item_t;

endpackage

`default_nettype wire

// ===== src/bma_ram.sv =====
// ----------------------------------------------------------------------------
// bma_ram
// Simple dual-port RAM, one write and one registered read port, read-first.
// ----------------------------------------------------------------------------
`default_nettype none

module bma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     aclk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic                                     re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns the old contents on a same-address write
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/bma_ctrl.sv =====
// ----------------------------------------------------------------------------
// bma_ctrl
// Window control: config registers, ring pointer, fill count, priming and
// RAM write/read addressing for each accepted sample.
// ----------------------------------------------------------------------------
`default_nettype none

module bma_ctrl (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // config write
    input  wire logic                               cfg_we,
    input  wire logic [bma_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [bma_pkg::CFG_DATA_W-1:0]     cfg_data,
    // sample request
    input  wire logic                               accept,
    input  wire logic signed [bma_pkg::SAMPLE_BITS-1:0] sample,
    // RAM access
    output logic                                    ram_we,
    output logic [bma_pkg::ADDR_W-1:0]              ram_addr,
    // to datapath
    output bma_pkg::bma_item_t                      item,
    output logic [bma_pkg::RECIP_W-1:0]             recip
);

    import bma_pkg::*;

    logic [WL_W-1:0]    wl_reg;
    logic [RECIP_W-1:0] recip_reg;
    logic [ADDR_W-1:0]  wp_reg,     wp_next;
    logic [EFF_W-1:0]   filled_reg, filled_next;
    logic               primed_reg;
    logic signed [SAMPLE_BITS-1:0] prime_val_reg;

    logic [EFF_W-1:0]   eff_len;
    logic [ADDR_W-1:0]  pos;
    logic [EFF_W-1:0]   pos_ext;
    logic [EFF_W-1:0]   filled_cur;
    logic signed [SUM_W-1:0] x_ext;
    logic signed [SUM_W-1:0] len_ext;

    // Effective length: zero counts as one, clamp at the window depth
    always_comb begin
        if (wl_reg == '0) begin
            eff_len = EFF_W'(1);
        end else if (wl_reg > WINDOW_MAX) begin
            eff_len = EFF_W'(WINDOW_MAX);
        end else begin
            eff_len = EFF_W'(wl_reg);
        end
    end

    // Position of this request, restarting at zero on priming
    always_comb begin
        if (!primed_reg) begin
            pos        = '0;
            filled_cur = '0;
        end else begin
            pos        = wp_reg;
            filled_cur = filled_reg;
        end
        if (EFF_W'(pos) >= eff_len) begin
            pos = '0;
        end
        pos_ext = EFF_W'(pos);

        if (pos_ext >= filled_cur) begin
            filled_next = pos_ext + EFF_W'(1);
        end else begin
            filled_next = filled_cur;
        end
        if (pos_ext + EFF_W'(1) >= eff_len) begin
            wp_next = '0;
        end else begin
            wp_next = pos + ADDR_W'(1);
        end
    end

    // Priming sum
    assign x_ext   = SUM_W'(sample);
    assign len_ext = signed'(SUM_W'(eff_len));

    always_comb begin
        item.x         = sample;
        item.alt_old   = primed_reg ? prime_val_reg : sample;
        item.from_mem  = pos_ext < filled_cur;
        item.prime     = !primed_reg;
        item.prime_sum = x_ext * len_ext;
    end

    assign ram_we   = accept;
    assign ram_addr = pos;
    assign recip    = recip_reg;

    // Control state and config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wl_reg        <= WL_RESET;
            recip_reg     <= RECIP_RESET;
            wp_reg        <= '0;
            filled_reg    <= '0;
            primed_reg    <= 1'b0;
            prime_val_reg <= '0;
        end else if (cfg_we) begin
            if (cfg_index == REG_WINDOW_LENGTH) begin
                wl_reg     <= cfg_data[WL_W-1:0];
                wp_reg     <= '0;
                filled_reg <= '0;
                primed_reg <= 1'b0;
                prime_val_reg <= '0;
            end else if (cfg_index == REG_LENGTH_RECIP) begin
                recip_reg <= cfg_data[RECIP_W-1:0];
            end
        end else if (accept) begin
            wp_reg     <= wp_next;
            filled_reg <= filled_next;
            primed_reg <= 1'b1;
            if (!primed_reg) begin
                prime_val_reg <= sample;
            end
        end
    end

    // Ring pointer and fill count stay inside the window
    a_wp_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        primed_reg |-> (EFF_W'(wp_reg) < eff_len))
        else $error("write pointer outside window");

    a_filled_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        filled_reg <= eff_len)
        else $error("fill count exceeds window length");

    // Priming restarts the ring at entry zero
    a_prime_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !primed_reg) |=> (filled_reg == EFF_W'(1)))
        else $error("priming did not restart the ring");

endmodule

`default_nettype wire

// ===== src/bma_datapath.sv =====
// ----------------------------------------------------------------------------
// bma_datapath
// Running sum update and scaling pipeline with per-stage flow control.
// ----------------------------------------------------------------------------
`default_nettype none

module bma_datapath (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                accept,
    output logic                                     in_ready,
    input  wire bma_pkg::bma_item_t                  item,
    input  wire logic [bma_pkg::SAMPLE_BITS-1:0]     rdata,
    input  wire logic [bma_pkg::RECIP_W-1:0]         recip,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [bma_pkg::SAMPLE_BITS-1:0]   out_avg
);

    import bma_pkg::*;

    localparam int PHI_W = HI_W + RECIP_W;
    localparam int PLO_W = FRAC_BITS + RECIP_W;
    localparam int Q_W   = PHI_W + 1;
    localparam logic [Q_W-1:0] SMAX_Q =
        Q_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic [Q_W-1:0] SMIN_MAG_Q = SMAX_Q + Q_W'(1);

    // stage 1: request with RAM read in flight
    logic                          v1_reg;
    bma_item_t                     it1_reg;
    // stage 2: updated sum
    logic                          v2_reg;
    logic signed [SUM_W-1:0]       s2_reg;
    // stage 3: sign and magnitude split
    logic                          v3_reg;
    logic                          neg3_reg;
    logic [HI_W-1:0]               hi3_reg;
    logic [FRAC_BITS-1:0]          lo3_reg;
    // stage 4: partial products
    logic                          v4_reg;
    logic                          neg4_reg;
    logic [PHI_W-1:0]              phi4_reg;
    logic [PLO_W-1:0]              plo4_reg;
    // output register
    logic                          vo_reg;
    logic signed [SAMPLE_BITS-1:0] avg_reg, avg_next;

    logic signed [SUM_W-1:0]       sum_reg, sum_next;
    logic signed [SAMPLE_BITS-1:0] old_val;
    logic [SUM_W-1:0]              mag;
    logic [Q_W-1:0]                q;

    logic free_o, free4, free3, free2, free1;
    logic adv1;

    // Flow control: a stage loads when it is empty or draining
    assign free_o = !vo_reg || out_ready;
    assign free4  = !v4_reg || free_o;
    assign free3  = !v3_reg || free4;
    assign free2  = !v2_reg || free3;
    assign free1  = !v1_reg || free2;
    assign adv1   = v1_reg && free2;
    assign in_ready = free1;

    // Running sum: add new sample, drop evicted one
    always_comb begin
        old_val  = it1_reg.from_mem ? signed'(rdata) : it1_reg.alt_old;
        sum_next = (it1_reg.prime ? it1_reg.prime_sum : sum_reg)
                   + SUM_W'(it1_reg.x) - SUM_W'(old_val);
    end

    // Magnitude of the sum
    assign mag = s2_reg[SUM_W-1] ? SUM_W'(-s2_reg) : SUM_W'(s2_reg);

    // Combine partial products, saturate, restore sign
    always_comb begin
        q = Q_W'(phi4_reg) + Q_W'(plo4_reg >> FRAC_BITS);
        if (neg4_reg) begin
            if (q > SMIN_MAG_Q) begin
                avg_next = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            end else begin
                avg_next = -signed'(q[SAMPLE_BITS-1:0]);
            end
        end else begin
            if (q > SMAX_Q) begin
                avg_next = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            end else begin
                avg_next = signed'(q[SAMPLE_BITS-1:0]);
            end
        end
    end

    // Valid bits and running sum
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            vo_reg  <= 1'b0;
            sum_reg <= '0;
        end else begin
            if (free1)  v1_reg <= accept;
            if (free2)  v2_reg <= adv1;
            if (free3)  v3_reg <= v2_reg;
            if (free4)  v4_reg <= v3_reg;
            if (free_o) vo_reg <= v4_reg;
            if (adv1)   sum_reg <= sum_next;
        end
    end

    // Stage payloads
    always_ff @(posedge aclk) begin
        if (free1 && accept) begin
            it1_reg <= item;
        end
        if (free2 && adv1) begin
            s2_reg <= sum_next;
        end
        if (free3 && v2_reg) begin
            neg3_reg <= s2_reg[SUM_W-1];
            hi3_reg  <= mag[SUM_W-1:FRAC_BITS];
            lo3_reg  <= mag[FRAC_BITS-1:0];
        end
        if (free4 && v3_reg) begin
            neg4_reg <= neg3_reg;
            phi4_reg <= PHI_W'(hi3_reg) * PHI_W'(recip);
            plo4_reg <= PLO_W'(lo3_reg) * PLO_W'(recip);
        end
        if (free_o && v4_reg) begin
            avg_reg <= avg_next;
        end
    end

    assign out_valid = vo_reg;
    assign out_avg   = avg_reg;

    // A held stage-1 request must not see a new RAM read
    a_no_read_over_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && !adv1) |-> !accept)
        else $error("RAM read issued over a held request");

    // Stalled result is not replaced
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (vo_reg && !out_ready) |=> (vo_reg && $stable(avg_reg)))
        else $error("pending result changed");

    // A priming request never takes its evicted value from the window store
    a_prime_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv1 && it1_reg.prime && it1_reg.from_mem) |-> 1'b0)
        else $error("priming request reads the window store");

endmodule

`default_nettype wire

// ===== src/boxcar_moving_average.sv =====
// ----------------------------------------------------------------------------
// boxcar_moving_average
// Running mean of the last window_length signed samples.
//
//   channel  direction  payload
//   s_       in         tdata[23:0] = sample
//   m_       out        tdata[23:0] = average
//   cfg_     in         cfg_index (0 window_length, 1 length_reciprocal),
//                       cfg_data
//
// One sample per cycle sustained while the output is not stalled; the window
// store takes one read and one write per request on separate RAM ports. An
// accepted sample passes through the RAM read, sum update, magnitude, products
// and saturation registers in that order. Synchronous active-low reset; no
// clearing pass, unwritten entries are covered by a fill count. A stalled
// output lets up to four further samples enter before s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module boxcar_moving_average (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // sample input: [23:0] sample
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [23:0]                      s_tdata,
    // result output: [23:0] average
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [23:0]                           m_tdata,
    // configuration writes
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [bma_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [bma_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import bma_pkg::*;

    logic                          accept;
    logic                          ram_we;
    logic [ADDR_W-1:0]             ram_addr;
    logic [SAMPLE_BITS-1:0]        ram_rdata;
    bma_item_t                     item;
    logic [RECIP_W-1:0]            recip;
    logic signed [SAMPLE_BITS-1:0] avg;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    // Window control
    bma_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .sample    (signed'(s_tdata[SAMPLE_BITS-1:0])),
        .ram_we    (ram_we),
        .ram_addr  (ram_addr),
        .item      (item),
        .recip     (recip)
    );

    // Window store, read-first at the same address
    bma_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (s_tdata[SAMPLE_BITS-1:0]),
        .re    (accept),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    // Sum and scaling pipeline
    bma_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .in_ready  (s_tready),
        .item      (item),
        .rdata     (ram_rdata),
        .recip     (recip),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_avg   (avg)
    );

    assign m_tdata = 24'(avg);

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the boxcar moving-average filter. A scoreboard
// keeps its own copy of the window, the running sum and both registers, and
// predicts one average per accepted sample. Every result is matched in order
// against those predictions. A short directed run covers the sample
// extremes, window length zero and above the maximum, the clear on a length
// write, mismatched reciprocals with saturation and unmapped register
// writes. A random run follows, with bursty input and a stalling output.
// ----------------------------------------------------------------------------

module testbench;

    import bma_pkg::*;

    localparam int RANDOM_ITEMS = 1050;
    localparam int DRAIN_CYCLES = 8;   // lets the pipeline empty
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [RECIP_W-1:0] RECIP_ONE = RECIP_W'(1) << FRAC_BITS;
    localparam logic [RECIP_W-1:0] RECIP_TOP = '1;

    // Indexes with no register behind them
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_LOW  = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_HIGH = '1;

    // ------------------------------------------------------------------
    // Scoreboard: window predictor plus the queue of expected averages
    // ------------------------------------------------------------------
    class avg_scoreboard;
        logic [WL_W-1:0]              window_length;
        logic [RECIP_W-1:0]           length_recip;
        logic signed [SAMPLE_BITS-1:0] ring [WINDOW_MAX];
        int unsigned                  wr_pos;
        int unsigned                  filled;
        longint                       run_sum;
        bit                           primed;
        logic signed [SAMPLE_BITS-1:0] prime_val;
        logic [SAMPLE_BITS-1:0]       expected_averages [$];
        int                           mismatches;

        function new();
            window_length = WL_RESET;
            length_recip  = RECIP_RESET;
            mismatches    = 0;
            clear_window();
        endfunction

        function void clear_window();
            wr_pos    = 0;
            filled    = 0;
            run_sum   = 0;
            primed    = 0;
            prime_val = '0;
        endfunction

        function int pending();
            return expected_averages.size();
        endfunction

        // Register write as accepted by the block
        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_WINDOW_LENGTH) begin
                window_length = data[WL_W-1:0];
                clear_window();
            end else if (idx == REG_LENGTH_RECIP) begin
                length_recip = data[RECIP_W-1:0];
            end
        endfunction

        // sum * recip / 2^FRAC_BITS, toward zero, saturated to the sample range
        function logic [SAMPLE_BITS-1:0] scaled_mean(longint sum, logic [RECIP_W-1:0] recip);
            logic [63:0] mag;
            logic [63:0] q;
            mag = (sum < 0) ? -sum : sum;
            q   = (mag * 64'(recip)) >> FRAC_BITS;
            if (sum < 0) begin
                if (q > 64'(SAMPLE_MIN))
                    return SAMPLE_MIN;
                return SAMPLE_BITS'(64'd0 - q);
            end
            if (q > 64'(SAMPLE_MAX))
                return SAMPLE_MAX;
            return q[SAMPLE_BITS-1:0];
        endfunction

        // Advance the window by one accepted sample and queue its average
        function void note_sample(logic [SAMPLE_BITS-1:0] raw);
            logic signed [SAMPLE_BITS-1:0] x;
            longint      len;
            longint      evicted;
            int unsigned pos;
            x = raw;
            if (window_length == 0)
                len = 1;
            else if (window_length > WINDOW_MAX)
                len = WINDOW_MAX;
            else
                len = window_length;

            // first sample after a clear fills the whole window
            if (!primed) begin
                prime_val = x;
                run_sum   = longint'(x) * len;
                primed    = 1;
                filled    = 0;
                wr_pos    = 0;
            end

            pos = wr_pos;
            if (pos >= len)
                pos = 0;
            if (pos < filled)
                evicted = ring[pos];
            else
                evicted = prime_val;
            ring[pos] = x;
            if (pos >= filled)
                filled = pos + 1;
            pos++;
            if (pos >= len)
                pos = 0;
            wr_pos = pos;

            run_sum = run_sum + longint'(x) - evicted;
            expected_averages.push_back(scaled_mean(run_sum, length_recip));
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= 30)
                $display("%0t: mismatch: %s", $time, msg);
        endtask

        task check_average(logic [SAMPLE_BITS-1:0] got);
            logic [SAMPLE_BITS-1:0] exp_avg;
            if (expected_averages.size() == 0) begin
                report_mismatch($sformatf("unexpected average %0d", $signed(got)));
            end else begin
                exp_avg = expected_averages.pop_front();
                if (got !== exp_avg)
                    report_mismatch($sformatf("average got %0d, expected %0d",
                                              $signed(got), $signed(exp_avg)));
            end
        endtask
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and block signals
    // ------------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [SAMPLE_BITS-1:0]  s_tdata   = '0;   // [23:0] sample
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [SAMPLE_BITS-1:0]  m_tdata;          // [23:0] average
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data  = '0;

    avg_scoreboard sb;
    int            burst_left = 0;
    logic [31:0]   rx_cycle   = '0;
    int            rx_mode    = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    boxcar_moving_average i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Result side: check accepted averages, stall in changing modes
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_average(m_tdata);
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle[6:0] == 7'd0)
            rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= (rx_cycle[3:0] >= 4'd6);   // periodic stall
            default: m_tready <= ($urandom_range(0, 9) < 3);
        endcase
    end

    // ------------------------------------------------------------------
    // Sample side: one request, in bursts separated by random gaps
    // ------------------------------------------------------------------
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] x);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        do @(posedge aclk); while (!s_tready);
        sb.note_sample(x);
        burst_left--;
    endtask

    // Register write, only once the filter has drained
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
    endtask

    // Reciprocal mostly matching the length, sometimes off or extreme
    function automatic logic [CFG_DATA_W-1:0] pick_recip(int eff);
        logic [CFG_DATA_W-1:0] r;
        case ($urandom_range(0, 9))
            7:       r = $urandom_range(0, 32'h1FF_FFFF);
            8:       r = RECIP_ONE;
            9:       r = $urandom_range(0, 1) ? RECIP_TOP : '0;
            default: r = (32'd1 << FRAC_BITS) / eff;
        endcase
        // junk above the register field is dropped by the block
        if ($urandom_range(0, 3) == 0)
            r = r | ($urandom & ~32'h1FF_FFFF);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int remaining;
        int n;
        int eff;
        int kind;
        logic [CFG_DATA_W-1:0]  raw_len;
        logic [SAMPLE_BITS-1:0] x;

        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset setting: length one, reciprocal one, average is the sample
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample('0);
        send_sample('1);

        // length zero behaves as one
        write_reg(REG_WINDOW_LENGTH, 32'd0);
        send_sample(24'sd5);
        send_sample(-24'sd7);

        // length three, extremes fill and wrap the window
        write_reg(REG_WINDOW_LENGTH, 32'd3);
        write_reg(REG_LENGTH_RECIP, 32'd5592405);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(24'd1);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);

        // oversized reciprocal keeps the window, saturates both ways
        write_reg(REG_LENGTH_RECIP, 32'(RECIP_TOP));
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MIN);

        // unmapped indexes, length above the maximum, masked reciprocal
        write_reg(REG_UNMAPPED_LOW, 32'hFFFF_FFFF);
        write_reg(REG_UNMAPPED_HIGH, 32'h0000_0000);
        write_reg(REG_WINDOW_LENGTH, 32'hFFFF_FFFF);
        write_reg(REG_LENGTH_RECIP, 32'hFE00_4000);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(24'd123);

        // zero reciprocal, then one over a full-size window
        write_reg(REG_LENGTH_RECIP, 32'd0);
        send_sample(24'd1);
        write_reg(REG_LENGTH_RECIP, 32'(RECIP_ONE));
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);

        // random phases
        eff       = WINDOW_MAX;
        remaining = RANDOM_ITEMS;
        while (remaining > 0) begin
            kind = $urandom_range(0, 9);
            if (kind == 9)
                write_reg(CFG_INDEX_W'($urandom_range(2, 255)), $urandom);
            if (kind < 3) begin
                // new reciprocal only, window carries on
                write_reg(REG_LENGTH_RECIP, pick_recip(eff));
            end else begin
                case ($urandom_range(0, 19))
                    0:       raw_len = 0;
                    1:       raw_len = 1;
                    2:       raw_len = WINDOW_MAX;
                    3:       raw_len = $urandom_range(WINDOW_MAX + 1, 2047);
                    4:       raw_len = 2047;
                    5, 6:    raw_len = $urandom_range(33, 300);
                    default: raw_len = $urandom_range(2, 32);
                endcase
                eff = (raw_len == 0) ? 1 : (raw_len > WINDOW_MAX) ? WINDOW_MAX : raw_len;
                if ($urandom_range(0, 3) == 0)
                    raw_len = raw_len | ($urandom & ~32'h7FF);
                write_reg(REG_WINDOW_LENGTH, raw_len);
                write_reg(REG_LENGTH_RECIP, pick_recip(eff));
            end

            n = (eff <= 32) ? $urandom_range(eff, 3 * eff + 40) : $urandom_range(20, 90);
            if (n > remaining)
                n = remaining;
            repeat (n) begin
                case ($urandom_range(0, 9))
                    6:       x = SAMPLE_MAX;
                    7:       x = SAMPLE_MIN;
                    8, 9:    x = SAMPLE_BITS'($urandom_range(0, 200) - 100);
                    default: x = SAMPLE_BITS'($urandom);
                endcase
                send_sample(x);
            end
            remaining -= n;
        end

        // drain and finish
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4 * DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Hang guard
    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/bma_pkg.sv
src/bma_ram.sv
src/bma_ctrl.sv
src/bma_datapath.sv
src/boxcar_moving_average.sv
tb/sv/testbench.sv
